/* rtl/core/internet_checksum_stream_core_macros.svh */
// Assertion macros shared by the checksum core modules.
// Depends on nothing; the using module must provide clk_i and rst_ni.
`ifndef INTERNET_CHECKSUM_STREAM_CORE_MACROS_SVH
`define INTERNET_CHECKSUM_STREAM_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ICS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ics assertion failed");
`define ICS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define ICS_ASSERT(lbl, prop)
`define ICS_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

/* rtl/core/ics_pkg.sv */
// Types, constants and the end-around add for the checksum core.
// No dependencies.
package ics_pkg;

  localparam int unsigned CountW    = 16;
  localparam int unsigned WordW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned InitW     = 32;
  localparam int unsigned QueueDepth = 2;
  localparam logic [WordW-1:0] WordMask = 16'hffff;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SKIP = 2'd1,
    PH_SUM  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic {
    ST_OK     = 1'b0,
    ST_NODATA = 1'b1
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [CountW-1:0] skip_bytes;
    logic [CountW-1:0] sum_length;
    logic [InitW-1:0]  seed_sum;
    logic [ByteW-1:0]  data_byte;
    logic              end_of_data;
  } op_t;

  // ones' complement add of two 16-bit words with end-around carry
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

/* rtl/core/ics_if.sv */
// Valid/ready channel interfaces for the checksum core: job/byte input and result.
// Depends on nothing.
interface ics_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] skip_bytes;
  logic [15:0] sum_length;
  logic [31:0] seed_sum;
  logic [7:0]  data_byte;
  logic        end_of_data;

  modport source (output valid, kind, skip_bytes, sum_length, seed_sum, data_byte,
                  end_of_data, input ready);
  modport sink   (input valid, kind, skip_bytes, sum_length, seed_sum, data_byte,
                  end_of_data, output ready);
endinterface

interface ics_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;
  logic        status;

  modport source (output valid, checksum, status, input ready);
  modport sink   (input valid, checksum, status, output ready);
endinterface

/* rtl/core/ics_front.sv */
// Front end: accepts input words and decodes them into queue entries.
// Depends on ics_pkg and ics_in_if.
module ics_front (
  ics_in_if.sink       in_i,
  input  logic         q_full_i,
  output logic         push_o,
  output ics_pkg::op_t op_o
);
  import ics_pkg::*;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    op_o.op          = in_i.kind ? OP_DATA : OP_START;
    op_o.skip_bytes  = in_i.skip_bytes;
    op_o.sum_length  = in_i.sum_length;
    op_o.seed_sum    = in_i.seed_sum;
    op_o.data_byte   = in_i.data_byte;
    // an end marker on a start word means nothing
    op_o.end_of_data = in_i.kind && in_i.end_of_data;
  end

endmodule

/* rtl/core/ics_queue.sv */
// Two-entry register queue between front and back end.
// Depends on ics_pkg and the assertion macros.
`include "internet_checksum_stream_core_macros.svh"

module ics_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ics_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output ics_pkg::op_t pop_op_o
);
  import ics_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o   = (count_q == CntW'(QueueDepth));
  assign valid_o  = (count_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  `ICS_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth))
  `ICS_ASSERT_MSG(a_no_push_full, !(push_i && full_o), "push into full queue")
  `ICS_ASSERT_MSG(a_pop_only_valid, pop_i |-> valid_o, "pop from empty queue")

endmodule

/* rtl/core/ics_back.sv */
// Back end: skip/sum sequencer with one end-around adder and a result register.
// Depends on ics_pkg, ics_out_if and the assertion macros.
`include "internet_checksum_stream_core_macros.svh"

module ics_back #(
  parameter int unsigned LengthBits = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  ics_pkg::op_t op_i,
  output logic         pop_o,
  ics_out_if.source    out_o
);
  import ics_pkg::*;

  phase_e                phase_q, phase_d;
  logic [LengthBits-1:0] skip_q, skip_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [WordW-1:0]      acc_q, acc_d;
  logic                  odd_q, odd_d;
  logic [ByteW-1:0]      held_q, held_d;
  logic                  out_valid_q, out_valid_d;
  logic [WordW-1:0]      cksum_q, cksum_d;
  status_e               status_q, status_d;

  logic                  emit;
  logic                  emit_err;
  logic [WordW-1:0]      add_a, add_b, add_res;
  logic [LengthBits-1:0] skip_dec, len_dec, len_load, skip_load;
  logic                  last_byte;

  assign pop_o     = q_valid_i && (!out_valid_q || out_o.ready);
  assign skip_load = LengthBits'(op_i.skip_bytes);
  assign len_load  = LengthBits'(op_i.sum_length);
  assign skip_dec  = skip_q - LengthBits'(1);
  assign len_dec   = len_q - LengthBits'(1);
  assign last_byte = (len_dec == '0);

  // one shared adder: folds the seed sum on a start, adds a word in summing
  always_comb begin
    if (op_i.op == OP_START) begin
      add_a = op_i.seed_sum[InitW-1:WordW];
      add_b = op_i.seed_sum[WordW-1:0];
    end else begin
      add_a = acc_q;
      add_b = odd_q ? {held_q, op_i.data_byte} : {op_i.data_byte, {ByteW{1'b0}}};
    end
    add_res = oc_add(add_a, add_b);
  end

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    len_d    = len_q;
    acc_d    = acc_q;
    odd_d    = odd_q;
    held_d   = held_q;
    emit     = 1'b0;
    emit_err = 1'b0;

    if (pop_o) begin
      if (op_i.op == OP_START) begin
        skip_d = skip_load;
        len_d  = len_load;
        acc_d  = add_res;
        odd_d  = 1'b0;
        held_d = '0;
        if (len_load == '0) begin
          emit    = 1'b1;
          phase_d = PH_DONE;
        end else begin
          phase_d = (skip_load != '0) ? PH_SKIP : PH_SUM;
        end
      end else begin
        case (phase_q)
          PH_SKIP: begin
            skip_d = skip_dec;
            if (op_i.end_of_data) begin
              emit     = 1'b1;
              emit_err = 1'b1;
              phase_d  = PH_DONE;
            end else if (skip_dec == '0) begin
              phase_d = PH_SUM;
            end
          end
          PH_SUM: begin
            len_d = len_dec;
            if (odd_q || last_byte) begin
              acc_d = add_res;
            end
            if (!odd_q) begin
              held_d = op_i.data_byte;
            end
            // a trailing odd byte is padded and added at once
            odd_d = !odd_q && !last_byte;
            if (last_byte) begin
              emit    = 1'b1;
              phase_d = PH_DONE;
            end else if (op_i.end_of_data) begin
              emit     = 1'b1;
              emit_err = 1'b1;
              phase_d  = PH_DONE;
            end
          end
          default: begin
            // drop bytes outside a job
          end
        endcase
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    cksum_d  = emit ? (emit_err ? '0 : (~acc_d & WordMask)) : cksum_q;
    status_d = emit ? (emit_err ? ST_NODATA : ST_OK) : status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skip_q   <= skip_d;
    len_q    <= len_d;
    acc_q    <= acc_d;
    odd_q    <= odd_d;
    held_q   <= held_d;
    cksum_q  <= cksum_d;
    status_q <= status_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.checksum = cksum_q;
  assign out_o.status   = status_q;

  `ICS_ASSERT_MSG(a_skip_nonzero, (phase_q == PH_SKIP) |-> (skip_q != '0),
                  "skipping with zero count")
  `ICS_ASSERT_MSG(a_len_nonzero, (phase_q == PH_SUM) |-> (len_q != '0),
                  "summing with zero length")
  `ICS_ASSERT_MSG(a_emit_done, emit |=> (phase_q == PH_DONE), "result without done")
  `ICS_ASSERT_MSG(a_err_zero, (out_valid_q && status_q == ST_NODATA) |-> (cksum_q == '0),
                  "error result with nonzero checksum")

endmodule

/* rtl/core/internet_checksum_stream_core.sv */
// Internet ones' complement checksum over a byte stream: top level.
// Input word: kind 0 starts a job (skip_bytes, sum_length, seed_sum),
// kind 1 carries one data byte with an end_of_data marker.
// The block drops skip_bytes bytes, then sums sum_length bytes as big-endian
// 16-bit words (an odd last byte is padded with zero) together with the
// folded seed sum, and returns the complemented 16-bit sum.
// A zero length answers on the start word itself. If end_of_data arrives
// before the length is reached, the result has status 1 and checksum 0.
// Bytes outside a job are dropped; a start word always aborts a running job.
// Throughput: one input word per cycle while the result receiver does not
// stall, held by the single 16-bit end-around adder in the back end. The
// completing word passes the queue, and the result is registered for out_o.
// A two-entry queue parts the front end from the back end; when the result
// receiver stalls, the back end holds its result and the queue fills, then
// in_i.ready drops. Reset (rst_ni low) empties the queue, drops any job and
// any pending result; no clearing pass is needed.
module internet_checksum_stream_core #(
  parameter int unsigned LengthBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ics_in_if.sink    in_i,
  ics_out_if.source out_o
);
  import ics_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  op_t  push_op;
  op_t  pop_op;

  ics_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (push_op)
  );

  ics_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .pop_op_o  (pop_op)
  );

  ics_back #(
    .LengthBits (LengthBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .op_i      (pop_op),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
